// File: rtl/core/umc_pkg.sv
// umc_pkg: shared types and constants of the unitary matrix check unit
// used by umc_ctrl, umc_dpath and the top level; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package umc_pkg;

	localparam int ELEM_W = 32;
	localparam int SIZE_W = 5;
	localparam int TOL_W  = 20;
	localparam int ACC_W  = 48;
	localparam int FRAC_W = 30;

	localparam logic [4:0]  SIZE_RST = 5'd16;
	localparam logic [19:0] TOL_RST  = 20'd11;

	// register indexes of the configuration port
	localparam logic REG_SIZE = 1'b0;
	localparam logic REG_TOL  = 1'b1;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_CHECK,
		ST_DRAIN
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic wr_en;
		logic rd_en;
		logic first;
		logic last;
		logic diag;
		logic fin;
		logic clear;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic done;
		logic pass;
	} sts_t;

endpackage
`default_nettype wire

// File: rtl/core/umc_ctrl.sv
// umc_ctrl: load and check sequencer of the unitary matrix check unit
// depends on umc_pkg
`timescale 1ns / 1ps
`default_nettype none
module umc_ctrl #(
	parameter int MAX_N = 16,
	parameter int IW    = $clog2(MAX_N),
	parameter int AW    = $clog2(MAX_N * MAX_N)
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [umc_pkg::SIZE_W-1:0]  size,
	input  wire logic                        size_wr,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        out_free,
	output logic                             publish,
	output umc_pkg::cmd_t                    cmd,
	output logic [AW-1:0]                    wr_addr,
	output logic [AW-1:0]                    rd_addr_a,
	output logic [AW-1:0]                    rd_addr_b,
	input  wire umc_pkg::sts_t               sts
);

	localparam int CW = (IW + 1 > umc_pkg::SIZE_W) ? IW + 1 : umc_pkg::SIZE_W;

	umc_pkg::state_t state_q, state_d;
	logic [IW-1:0] row_q, col_q;
	logic [IW-1:0] i_q, j_q, k_q;
	logic [IW-1:0] nm1;
	logic [CW-1:0] sz_c;
	logic          load_end, k_end, fin;
	logic          accept;

	// effective size minus one
	always_comb begin
		sz_c = CW'(size);
		if (sz_c == '0) begin
			nm1 = '0;
		end else if (sz_c > CW'(MAX_N)) begin
			nm1 = IW'(MAX_N - 1);
		end else begin
			nm1 = IW'(sz_c - CW'(1));
		end
	end

	assign accept    = in_valid && in_ready;
	assign load_end  = (row_q == nm1) && (col_q == nm1);
	assign k_end     = (k_q == nm1);
	assign fin       = k_end && (i_q == nm1) && (j_q == nm1);
	assign wr_addr   = AW'(row_q) * AW'(MAX_N) + AW'(col_q);
	assign rd_addr_a = AW'(k_q) * AW'(MAX_N) + AW'(i_q);
	assign rd_addr_b = AW'(k_q) * AW'(MAX_N) + AW'(j_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			umc_pkg::ST_LOAD: begin
				if (accept && load_end) state_d = umc_pkg::ST_CHECK;
			end
			umc_pkg::ST_CHECK: begin
				if (fin) state_d = umc_pkg::ST_DRAIN;
			end
			umc_pkg::ST_DRAIN: begin
				if (sts.done && out_free) state_d = umc_pkg::ST_LOAD;
			end
			default: state_d = umc_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		publish  = 1'b0;
		unique case (state_q)
			umc_pkg::ST_LOAD: begin
				in_ready   = 1'b1;
				cmd.wr_en  = in_valid;
				cmd.clear  = accept && load_end;
			end
			umc_pkg::ST_CHECK: begin
				cmd.rd_en = 1'b1;
				cmd.first = (k_q == '0);
				cmd.last  = k_end;
				cmd.diag  = (i_q == j_q);
				cmd.fin   = fin;
			end
			umc_pkg::ST_DRAIN: begin
				publish = sts.done && out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= umc_pkg::ST_LOAD;
			row_q   <= '0;
			col_q   <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (size_wr) begin
				row_q <= '0;
				col_q <= '0;
			end else if (accept) begin
				if (col_q == nm1) begin
					col_q <= '0;
					row_q <= load_end ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			if (state_q == umc_pkg::ST_CHECK) begin
				if (k_end) begin
					k_q <= '0;
					if (j_q == nm1) begin
						j_q <= '0;
						i_q <= (i_q == nm1) ? '0 : i_q + 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end else begin
					k_q <= k_q + 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/umc_dpath.sv
// umc_dpath: element store, complex multiply-accumulate pipeline and compare
// depends on umc_pkg
`timescale 1ns / 1ps
`default_nettype none
module umc_dpath #(
	parameter int MAX_N = 16,
	parameter int AW    = $clog2(MAX_N * MAX_N)
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire umc_pkg::cmd_t                     cmd,
	input  wire logic [AW-1:0]                     wr_addr,
	input  wire logic [AW-1:0]                     rd_addr_a,
	input  wire logic [AW-1:0]                     rd_addr_b,
	input  wire logic [2*umc_pkg::ELEM_W-1:0]      wr_data,
	input  wire logic [umc_pkg::TOL_W-1:0]         tol,
	output umc_pkg::sts_t                          sts
);

	localparam int EW = umc_pkg::ELEM_W;
	localparam int PW = 2 * EW;
	localparam int RW = PW - umc_pkg::FRAC_W;
	localparam int SW = RW + 1;
	localparam int AC = umc_pkg::ACC_W;

	logic [PW-1:0] mem [MAX_N*MAX_N];

	logic [PW-1:0] a_s1, b_s1;
	logic v_s1, last_s1, first_s1, diag_s1, fin_s1;
	logic signed [PW-1:0] p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2;
	logic v_s2, last_s2, first_s2, diag_s2, fin_s2;
	logic signed [SW-1:0] t_re_s3, t_im_s3;
	logic v_s3, last_s3, first_s3, diag_s3, fin_s3;
	logic chk_s4, diag_s4, fin_s4;
	logic signed [AC-1:0] acc_re_q, acc_im_q;
	logic fail_q, done_q;

	logic signed [RW-1:0] r_rr, r_ii, r_ri, r_ir;
	logic signed [AC:0] d_re, d_im, tol_p, tol_n;
	logic bad;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) mem[wr_addr] <= wr_data;
		if (cmd.rd_en) begin
			a_s1 <= mem[rd_addr_a];
			b_s1 <= mem[rd_addr_b];
		end
	end

	// conj(a) * b, four real products
	always_ff @(posedge clk) begin
		p_rr_s2 <= $signed(a_s1[EW-1:0])  * $signed(b_s1[EW-1:0]);
		p_ii_s2 <= $signed(a_s1[PW-1:EW]) * $signed(b_s1[PW-1:EW]);
		p_ri_s2 <= $signed(a_s1[EW-1:0])  * $signed(b_s1[PW-1:EW]);
		p_ir_s2 <= $signed(a_s1[PW-1:EW]) * $signed(b_s1[EW-1:0]);
	end

	// round half up to q30
	function automatic logic signed [RW-1:0] rnd(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] t;
		t = p + (PW'(1) <<< (umc_pkg::FRAC_W - 1));
		return RW'(t >>> umc_pkg::FRAC_W);
	endfunction

	assign r_rr = rnd(p_rr_s2);
	assign r_ii = rnd(p_ii_s2);
	assign r_ri = rnd(p_ri_s2);
	assign r_ir = rnd(p_ir_s2);

	always_ff @(posedge clk) begin
		t_re_s3 <= SW'(r_rr) + SW'(r_ii);
		t_im_s3 <= SW'(r_ri) - SW'(r_ir);
		if (v_s3) begin
			acc_re_q <= (first_s3 ? AC'(0) : acc_re_q) + AC'(t_re_s3);
			acc_im_q <= (first_s3 ? AC'(0) : acc_im_q) + AC'(t_im_s3);
		end
	end

	// deviation from identity
	always_comb begin
		d_re  = (AC + 1)'(acc_re_q) - (diag_s4 ? ((AC + 1)'(1) <<< umc_pkg::FRAC_W) : '0);
		d_im  = (AC + 1)'(acc_im_q);
		tol_p = $signed({{(AC + 1 - umc_pkg::TOL_W){1'b0}}, tol});
		tol_n = -tol_p;
		bad   = (d_re > tol_p) || (d_re < tol_n) || (d_im > tol_p) || (d_im < tol_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, chk_s4} <= '0;
			{last_s1, last_s2, last_s3} <= '0;
			{first_s1, first_s2, first_s3} <= '0;
			{diag_s1, diag_s2, diag_s3, diag_s4} <= '0;
			{fin_s1, fin_s2, fin_s3, fin_s4} <= '0;
			fail_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_en;  first_s1 <= cmd.first; last_s1 <= cmd.last;
			diag_s1 <= cmd.diag; fin_s1 <= cmd.fin && cmd.rd_en;
			v_s2 <= v_s1; first_s2 <= first_s1; last_s2 <= last_s1;
			diag_s2 <= diag_s1; fin_s2 <= fin_s1;
			v_s3 <= v_s2; first_s3 <= first_s2; last_s3 <= last_s2;
			diag_s3 <= diag_s2; fin_s3 <= fin_s2;
			chk_s4 <= v_s3 && last_s3;
			diag_s4 <= diag_s3;
			fin_s4 <= fin_s3;
			if (cmd.clear) begin
				fail_q <= 1'b0;
				done_q <= 1'b0;
			end else if (chk_s4) begin
				if (bad) fail_q <= 1'b1;
				if (fin_s4) done_q <= 1'b1;
			end
		end
	end

	assign sts.done = done_q;
	assign sts.pass = !fail_q;

endmodule
`default_nettype wire

// File: rtl/core/unitary_matrix_check_unit.sv
// unitary_matrix_check_unit: top level, config registers and result register
// depends on umc_pkg, umc_ctrl, umc_dpath
//
// usage:
//   s_* channel takes one matrix element per item, row-major, n*n items per matrix
//   m_* channel gives one item per complete matrix: m_tdata[0] = 1 when
//   conj(M)^T M equals identity within the tolerance on every component
//   config: cfg_we writes register cfg_index (0 = matrix size, 1 = tolerance)
//   a size write restarts loading of the current matrix
// timing:
//   loading accepts one element per cycle
//   the check works through the n^3 products on the one complex multiply-accumulate unit
//   fed from the two read ports of the store; products pass the read, product
//   and sum registers into the accumulator, the verdict the check and done flags
//   and the result register; no element is taken while a matrix is checked
// reset: size 16, tolerance 11, loading restarts at element 0, no result pending
// stall: a result waits in the output register; a finished check holds its
//   verdict until that register is free, and no element is taken meanwhile
`timescale 1ns / 1ps
`default_nettype none
module unitary_matrix_check_unit #(
	parameter int MAX_N = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// element items
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [63:0]                   s_tdata,   // elem_re[31:0], elem_im[63:32]
	// result items
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [7:0]                         m_tdata,   // is_unitary[0], zero fill
	// configuration
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_index,
	input  wire logic [umc_pkg::TOL_W-1:0]     cfg_data
);

	localparam int IW = $clog2(MAX_N);
	localparam int AW = $clog2(MAX_N * MAX_N);

	logic [umc_pkg::SIZE_W-1:0] size_q;
	logic [umc_pkg::TOL_W-1:0]  tol_q;
	logic                       size_wr;
	logic                       out_free, publish;
	logic                       res_q;
	logic                       m_valid_q;
	umc_pkg::cmd_t              cmd;
	umc_pkg::sts_t              sts;
	logic [AW-1:0]              wr_addr, rd_addr_a, rd_addr_b;

	assign size_wr = cfg_we && (cfg_index == umc_pkg::REG_SIZE);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= umc_pkg::SIZE_RST;
			tol_q  <= umc_pkg::TOL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				umc_pkg::REG_SIZE: size_q <= cfg_data[umc_pkg::SIZE_W-1:0];
				umc_pkg::REG_TOL:  tol_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// result register, free when empty or taken this cycle
	assign out_free = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (publish) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (publish) res_q <= sts.pass;
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'd0, res_q};

	umc_ctrl #(.MAX_N(MAX_N), .IW(IW), .AW(AW)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.size      (size_q),
		.size_wr   (size_wr),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_free  (out_free),
		.publish   (publish),
		.cmd       (cmd),
		.wr_addr   (wr_addr),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.sts       (sts)
	);

	umc_dpath #(.MAX_N(MAX_N), .AW(AW)) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.wr_addr   (wr_addr),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.wr_data   (s_tdata),
		.tol       (tol_q),
		.sts       (sts)
	);

endmodule
`default_nettype wire

// File: rtl/core/umc_chk.sv
// umc_chk: port-level checker of the unitary matrix check unit
// bound to unitary_matrix_check_unit; no other dependencies
`timescale 1ns / 1ps
`default_nettype none
module umc_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tready,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata
);

	// stalled result stays
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	// a result is published only after the check, when no element is taken
	a_pub: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared during loading");

	// fill bits of the result stay zero
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:1] == 7'd0))
		else $error("nonzero fill bits in result");

endmodule

bind unitary_matrix_check_unit umc_chk u_umc_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
